>>> sv/dimh_pkg.sv
// Shared types and constants for the dual indexed max-heap.
`timescale 1ns / 1ps
package dimh_pkg;
   localparam int NUM_VERTICES = 1024;
   localparam int VERT_BITS    = 10;
   localparam int POS_BITS     = 11;
   localparam int GAIN_BITS    = 32;

   typedef logic [VERT_BITS-1:0] vert_type;
   typedef logic [POS_BITS-1:0]  pos_type;
   typedef logic signed [GAIN_BITS-1:0] gain_type;

   localparam logic [1:0] ACT_INSERT = 2'd0;
   localparam logic [1:0] ACT_REMOVE = 2'd1;
   localparam logic [1:0] ACT_CLEAR  = 2'd2;
   localparam logic [1:0] ACT_NOP    = 2'd3;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_PRESENT = 2'd1;
   localparam logic [1:0] ST_ABSENT  = 2'd2;
endpackage

>>> sv/dimh_ram.sv
// Single-port-write, registered-read RAM used for heap, gain and map stores.
`timescale 1ns / 1ps
module dimh_ram #(
   parameter int WIDTH = 10,
   parameter int DEPTH = 1024,
   parameter int ABITS = 10
) (
   input  logic             clock,
   input  logic             we,
   input  logic [ABITS-1:0] waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [ABITS-1:0] raddr,
   output logic [WIDTH-1:0] rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      rdata <= mem[raddr];
   end
endmodule

>>> sv/dual_indexed_max_heap_core.sv
// Top level: two indexed max-heaps sharing one sequencer and one gain comparator.
`timescale 1ns / 1ps
//  channel | ports                         | handshake
//  request | req_action/vertex/side/gain   | start high while busy low
//  result  | rsp_* fields                  | rsp_valid, one cycle, cannot stall
//
//  Insert climbs level by level toward the root; remove moves the last
//  slot into the hole and sifts it; clear visits every member of both heaps.
//  The strobe follows in the cycle after S_DONE, where busy is already low.
//  After reset the position map is cleared for all 1024 vertices; busy is
//  held high meanwhile. The result strobe cannot be held off.
module dual_indexed_max_heap_core
   import dimh_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           start,
   output logic           busy,
   input  logic [1:0]     req_action,
   input  logic [9:0]     req_vertex,
   input  logic           req_side,
   input  logic signed [31:0] req_gain,
   output logic           rsp_valid,
   output logic [9:0]     rsp_top_vertex_zero,
   output logic signed [31:0] rsp_top_gain_zero,
   output logic [9:0]     rsp_top_vertex_one,
   output logic signed [31:0] rsp_top_gain_one,
   output logic [10:0]    rsp_count_zero,
   output logic [10:0]    rsp_count_one,
   output logic [1:0]     rsp_status
);
   typedef enum logic [4:0] {
      S_INIT, S_IDLE, S_MAPRD, S_MAPCHK, S_INS,
      S_RMLAST, S_RMLAST2, S_RMMOVE,
      S_UPRD, S_UPG, S_UPCMP,
      S_DNRD, S_DNL, S_DNR, S_DNCMP, S_DNMOVE,
      S_CLRD, S_CLWAIT, S_CLWR,
      S_TOPRD, S_TOPG, S_TOPG2, S_DONE
   } state_type;

   state_type state_ff;

   // memories: heap store per side (shared address), gain table, map
   logic     h_we [2];
   pos_type  h_wa, h_ra;
   vert_type h_wd;
   vert_type h_rd [2];
   logic     g_we;
   vert_type g_wa, g_ra;
   gain_type g_wd, g_rd;
   logic     m_we;
   vert_type m_wa, m_ra;
   pos_type  m_wd, m_rd;

   for (genvar s = 0; s < 2; s++) begin : g_heap
      dimh_ram #(.WIDTH(VERT_BITS), .DEPTH(NUM_VERTICES), .ABITS(VERT_BITS)) u_heap (
         .clock(clock), .we(h_we[s]), .waddr(h_wa[VERT_BITS-1:0]), .wdata(h_wd),
         .raddr(h_ra[VERT_BITS-1:0]), .rdata(h_rd[s]));
   end
   dimh_ram #(.WIDTH(GAIN_BITS), .DEPTH(NUM_VERTICES), .ABITS(VERT_BITS)) u_gain (
      .clock(clock), .we(g_we), .waddr(g_wa), .wdata(g_wd), .raddr(g_ra), .rdata(g_rd));
   dimh_ram #(.WIDTH(POS_BITS), .DEPTH(NUM_VERTICES), .ABITS(VERT_BITS)) u_map (
      .clock(clock), .we(m_we), .waddr(m_wa), .wdata(m_wd), .raddr(m_ra), .rdata(m_rd));

   logic [1:0] act_ff;
   vert_type   vert_ff;     // item being sifted
   logic       side_ff, cside_ff;
   gain_type   gain_ff;     // gain of the item being sifted
   pos_type    size_ff [2];
   pos_type    pos_ff, lim_ff, idx_ff;
   vert_type   vtmp_ff, lv_ff;
   gain_type   lg_ff;       // gain of the neighbour that may swap
   logic       sel_right_ff;
   logic [1:0] status_ff;
   logic       dn_ff;       // sift-down follows sift-up
   vert_type   top_v_ff [2];
   gain_type   top_g_ff [2];
   logic       rsp_valid_ff;

   pos_type parent, lpos, rpos;
   assign parent = (pos_ff - 11'd1) >> 1;
   assign lpos   = {pos_ff[POS_BITS-2:0], 1'b1};
   assign rpos   = lpos + 11'd1;

   // shared signed comparator
   gain_type cmp_a, cmp_b;
   logic     cmp_lt;
   assign cmp_lt = cmp_a < cmp_b;

   vert_type hrd;
   assign hrd = h_rd[side_ff];

   // Sifting keeps the moving item in registers: each step writes the
   // neighbour into the hole, and the item is written where it comes to rest.
   always_comb begin
      h_we[0] = 1'b0; h_we[1] = 1'b0; h_wa = pos_ff; h_wd = vert_ff; h_ra = pos_ff;
      g_we = 1'b0; g_wa = vert_ff; g_wd = gain_ff; g_ra = hrd;
      m_we = 1'b0; m_wa = vert_ff; m_wd = pos_ff + 11'd1; m_ra = vert_ff;
      cmp_a = gain_ff; cmp_b = g_rd;
      case (state_ff)
         S_INIT: begin m_we = 1'b1; m_wa = idx_ff[VERT_BITS-1:0]; m_wd = '0; end
         S_IDLE: begin m_ra = req_vertex; h_ra = 11'd0; end
         S_MAPCHK: h_ra = m_rd - 11'd1;
         S_INS: g_we = 1'b1;
         S_RMLAST: h_ra = size_ff[side_ff] - 11'd1;
         S_RMMOVE: begin m_we = 1'b1; m_wd = '0; end  // removed vertex leaves the map
         S_UPRD: begin
            h_ra = parent;
            if (pos_ff == '0) begin h_we[side_ff] = 1'b1; m_we = 1'b1; end
         end
         S_UPCMP: begin
            // parent gain below item gain: parent moves down into the hole
            cmp_a = g_rd; cmp_b = gain_ff;
            h_we[side_ff] = 1'b1; m_we = 1'b1;
            if (cmp_lt) begin h_wd = lv_ff; m_wa = lv_ff; end
         end
         S_DNRD: begin
            h_ra = lpos;
            if (lpos >= lim_ff) begin h_we[side_ff] = 1'b1; m_we = 1'b1; end
         end
         S_DNL: h_ra = rpos;
         S_DNCMP: begin cmp_a = g_rd; cmp_b = lg_ff; end
         S_DNMOVE: begin
            cmp_a = gain_ff; cmp_b = lg_ff;
            h_we[side_ff] = 1'b1; m_we = 1'b1;
            if (cmp_lt) begin h_wd = lv_ff; m_wa = lv_ff; end
         end
         S_CLRD, S_CLWAIT: h_ra = idx_ff;
         S_CLWR: begin m_we = 1'b1; m_wa = h_rd[cside_ff]; m_wd = '0; end
         S_TOPRD: h_ra = 11'd0;
         S_TOPG: begin h_ra = 11'd0; g_ra = h_rd[0]; end
         S_TOPG2: g_ra = top_v_ff[1];
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT; idx_ff <= '0;
         size_ff[0] <= '0; size_ff[1] <= '0;
         top_v_ff[0] <= '0; top_v_ff[1] <= '0;
         top_g_ff[0] <= '0; top_g_ff[1] <= '0;
         status_ff <= ST_OK;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= (state_ff == S_DONE);
         case (state_ff)
            S_INIT: begin
               idx_ff <= idx_ff + 11'd1;
               if (idx_ff == 11'(NUM_VERTICES - 1)) state_ff <= S_IDLE;
            end
            S_IDLE: if (start) begin
               act_ff <= req_action; vert_ff <= req_vertex; side_ff <= req_side;
               gain_ff <= req_gain; status_ff <= ST_OK; dn_ff <= 1'b0;
               if (req_action == ACT_CLEAR) begin
                  idx_ff <= '0; cside_ff <= 1'b0; state_ff <= S_CLRD;
               end else if (req_action == ACT_INSERT || req_action == ACT_REMOVE)
                  state_ff <= S_MAPRD;
               else state_ff <= S_TOPRD;
            end
            S_MAPRD: state_ff <= S_MAPCHK; // map data valid next
            S_MAPCHK: begin
               if (act_ff == ACT_INSERT) begin
                  if (m_rd != '0 || size_ff[side_ff] >= 11'(NUM_VERTICES)) begin
                     status_ff <= ST_PRESENT; state_ff <= S_TOPRD;
                  end else begin pos_ff <= size_ff[side_ff]; state_ff <= S_INS; end
               end else if (m_rd == '0 || (m_rd - 11'd1) >= size_ff[side_ff]) begin
                  status_ff <= ST_ABSENT; state_ff <= S_TOPRD;
               end else begin pos_ff <= m_rd - 11'd1; state_ff <= S_RMLAST; end
            end
            S_INS: begin
               size_ff[side_ff] <= size_ff[side_ff] + 11'd1;
               state_ff <= S_UPRD;
            end
            S_RMLAST: begin
               // vertex must sit in the selected heap
               if (hrd != vert_ff) begin status_ff <= ST_ABSENT; state_ff <= S_TOPRD; end
               else begin
                  lim_ff <= size_ff[side_ff] - 11'd1;
                  size_ff[side_ff] <= size_ff[side_ff] - 11'd1;
                  state_ff <= S_RMLAST2;
               end
            end
            S_RMLAST2: begin lv_ff <= hrd; state_ff <= S_RMMOVE; end // last vertex
            S_RMMOVE: begin
               if (pos_ff == lim_ff) state_ff <= S_TOPRD;
               else begin
                  vert_ff <= lv_ff; gain_ff <= g_rd; dn_ff <= 1'b1; state_ff <= S_UPRD;
               end
            end
            S_UPRD: begin
               if (pos_ff == '0) state_ff <= dn_ff ? S_DNRD : S_TOPRD;
               else state_ff <= S_UPG;
            end
            S_UPG: begin lv_ff <= hrd; state_ff <= S_UPCMP; end
            S_UPCMP: begin
               if (cmp_lt) begin
                  // a climb means the item already beats its new children
                  pos_ff <= parent; dn_ff <= 1'b0; state_ff <= S_UPRD;
               end else state_ff <= dn_ff ? S_DNRD : S_TOPRD;
            end
            S_DNRD: begin
               if (lpos >= lim_ff) state_ff <= S_TOPRD;
               else state_ff <= S_DNL;
            end
            S_DNL: begin lv_ff <= hrd; state_ff <= S_DNR; end
            S_DNR: begin lg_ff <= g_rd; vtmp_ff <= hrd; state_ff <= S_DNCMP; end
            S_DNCMP: begin
               // take the left child only when the right is absent or strictly smaller
               if (rpos >= lim_ff || cmp_lt) sel_right_ff <= 1'b0;
               else begin
                  sel_right_ff <= 1'b1; lg_ff <= g_rd; lv_ff <= vtmp_ff;
               end
               state_ff <= S_DNMOVE;
            end
            S_DNMOVE: begin
               if (cmp_lt) begin
                  pos_ff <= sel_right_ff ? rpos : lpos; state_ff <= S_DNRD;
               end else state_ff <= S_TOPRD;
            end
            S_CLRD: begin
               if (idx_ff >= size_ff[cside_ff]) begin
                  if (cside_ff) begin
                     size_ff[0] <= '0; size_ff[1] <= '0; state_ff <= S_TOPRD;
                  end else begin cside_ff <= 1'b1; idx_ff <= '0; end
               end else state_ff <= S_CLWAIT;
            end
            S_CLWAIT: state_ff <= S_CLWR;
            S_CLWR: begin idx_ff <= idx_ff + 11'd1; state_ff <= S_CLRD; end
            S_TOPRD: state_ff <= S_TOPG;
            S_TOPG: begin top_v_ff[0] <= h_rd[0]; top_v_ff[1] <= h_rd[1];
               state_ff <= S_TOPG2; end
            S_TOPG2: begin top_g_ff[0] <= g_rd; state_ff <= S_DONE; end
            S_DONE: begin
               top_g_ff[1] <= g_rd; state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign busy = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_top_vertex_zero = size_ff[0] != '0 ? top_v_ff[0] : '0;
   assign rsp_top_gain_zero   = size_ff[0] != '0 ? top_g_ff[0] : '0;
   assign rsp_top_vertex_one  = size_ff[1] != '0 ? top_v_ff[1] : '0;
   assign rsp_top_gain_one    = size_ff[1] != '0 ? top_g_ff[1] : '0;
   assign rsp_count_zero = size_ff[0];
   assign rsp_count_one  = size_ff[1];
   assign rsp_status     = status_ff;

   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("double strobe");
   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy) else $error("strobe while busy");
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy) else $error("accepted item not started");
   a_size_zero: assert property (@(posedge clock) disable iff (reset)
      size_ff[0] <= 11'(NUM_VERTICES)) else $error("size 0 overflow");
   a_size_one: assert property (@(posedge clock) disable iff (reset)
      size_ff[1] <= 11'(NUM_VERTICES)) else $error("size 1 overflow");
endmodule

>>> tb/tb.sv
// Self-checking testbench for the dual indexed max-heap core.
`timescale 1ns / 1ps

module tb;
   import dimh_pkg::*;

   typedef struct {
      vert_type    vz;
      gain_type    gz;
      vert_type    vo;
      gain_type    go;
      pos_type     cz;
      pos_type     co;
      logic [1:0]  st;
   } snapshot_t;

   // Heap predictor plus queue of expected root/count/status items.
   class heap_scoreboard;
      gain_type    gains[NUM_VERTICES];
      vert_type    heap_a[2][NUM_VERTICES];
      int          posmap[NUM_VERTICES];
      int          fill[2];
      snapshot_t   pending[$];
      int          errors;
      int          checked;

      function new();
         foreach (posmap[i]) posmap[i] = 0;
         fill[0] = 0;
         fill[1] = 0;
         errors = 0;
         checked = 0;
      endfunction

      function void place(int s, int p, vert_type v);
         heap_a[s][p] = v;
         posmap[v] = p + 1;
      endfunction

      function void climb(int s, int p);
         vert_type v;
         vert_type pv;
         int par;
         v = heap_a[s][p];
         while (p > 0) begin
            par = (p - 1) / 2;
            pv = heap_a[s][par];
            if (!(gains[pv] < gains[v])) break;
            place(s, par, v);
            place(s, p, pv);
            p = par;
         end
      endfunction

      function void sink(int s, int n, int p);
         vert_type v;
         vert_type cv;
         int lp;
         int rp;
         int cp;
         bit lok;
         bit rok;
         bit lb;
         bit rb;
         v = heap_a[s][p];
         while (p < n) begin
            lp = 2 * p + 1;
            rp = lp + 1;
            lok = lp < n;
            rok = rp < n;
            lb = lok && (gains[v] < gains[heap_a[s][lp]]);
            rb = rok && (gains[v] < gains[heap_a[s][rp]]);
            if (!lb && !rb) break;
            // equal children: right one moves up
            if (lok && (!rok || gains[heap_a[s][lp]] > gains[heap_a[s][rp]])) cp = lp;
            else cp = rp;
            cv = heap_a[s][cp];
            place(s, p, cv);
            place(s, cp, v);
            p = cp;
         end
      endfunction

      function void note_item(logic [1:0] act, vert_type v, logic sd, gain_type g);
         snapshot_t e;
         int s;
         int p;
         int last;
         s = sd;
         e.st = ST_OK;
         if (act == ACT_CLEAR) begin
            for (int k = 0; k < 2; k++)
               for (int i = 0; i < fill[k]; i++) posmap[heap_a[k][i]] = 0;
            fill[0] = 0;
            fill[1] = 0;
         end else if (act == ACT_INSERT) begin
            if (posmap[v] != 0 || fill[s] >= NUM_VERTICES) e.st = ST_PRESENT;
            else begin
               gains[v] = g;
               place(s, fill[s], v);
               fill[s]++;
               climb(s, fill[s] - 1);
            end
         end else if (act == ACT_REMOVE) begin
            p = posmap[v] - 1;
            if (posmap[v] == 0 || p >= fill[s] || heap_a[s][p] != v) e.st = ST_ABSENT;
            else begin
               last = fill[s] - 1;
               fill[s] = last;
               if (p != last) place(s, p, heap_a[s][last]);
               posmap[v] = 0;
               if (p != last) begin
                  climb(s, p);
                  sink(s, last, p);
               end
            end
         end
         e.vz = (fill[0] != 0) ? heap_a[0][0] : '0;
         e.gz = (fill[0] != 0) ? gains[heap_a[0][0]] : '0;
         e.vo = (fill[1] != 0) ? heap_a[1][0] : '0;
         e.go = (fill[1] != 0) ? gains[heap_a[1][0]] : '0;
         e.cz = pos_type'(fill[0]);
         e.co = pos_type'(fill[1]);
         pending.push_back(e);
      endfunction

      function void check_item(snapshot_t got);
         snapshot_t e;
         checked++;
         if (pending.size() == 0) begin
            $display("%0t: result with nothing expected", $time);
            errors++;
            return;
         end
         e = pending.pop_front();
         if (got.vz !== e.vz) begin
            $display("%0t: top_vertex_zero exp %0d got %0d", $time, e.vz, got.vz); errors++;
         end
         if (got.gz !== e.gz) begin
            $display("%0t: top_gain_zero exp %0d got %0d", $time, e.gz, got.gz); errors++;
         end
         if (got.vo !== e.vo) begin
            $display("%0t: top_vertex_one exp %0d got %0d", $time, e.vo, got.vo); errors++;
         end
         if (got.go !== e.go) begin
            $display("%0t: top_gain_one exp %0d got %0d", $time, e.go, got.go); errors++;
         end
         if (got.cz !== e.cz) begin
            $display("%0t: count_zero exp %0d got %0d", $time, e.cz, got.cz); errors++;
         end
         if (got.co !== e.co) begin
            $display("%0t: count_one exp %0d got %0d", $time, e.co, got.co); errors++;
         end
         if (got.st !== e.st) begin
            $display("%0t: status exp %0d got %0d", $time, e.st, got.st); errors++;
         end
      endfunction
   endclass

   localparam int CYCLE_LIMIT = 2_000_000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [1:0]  req_action = ACT_INSERT;
   logic [9:0]  req_vertex = '0;
   logic        req_side = 1'b0;
   logic signed [31:0] req_gain = '0;
   logic        rsp_valid;
   logic [9:0]  rsp_top_vertex_zero;
   logic signed [31:0] rsp_top_gain_zero;
   logic [9:0]  rsp_top_vertex_one;
   logic signed [31:0] rsp_top_gain_one;
   logic [10:0] rsp_count_zero;
   logic [10:0] rsp_count_one;
   logic [1:0]  rsp_status;

   heap_scoreboard heap_sb = new();
   int unsigned cycles = 0;
   int n_ins = 0;
   int n_rem = 0;
   int n_clr = 0;

   always #5 clock = ~clock;

   dual_indexed_max_heap_core u_dut (.*);

   // results cannot be stalled: take every strobe as it comes
   always @(posedge clock) begin
      snapshot_t r;
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("dual_indexed_max_heap_core verification failed");
         $finish;
      end
      if (!reset && rsp_valid) begin
         r.vz = rsp_top_vertex_zero;
         r.gz = rsp_top_gain_zero;
         r.vo = rsp_top_vertex_one;
         r.go = rsp_top_gain_one;
         r.cz = rsp_count_zero;
         r.co = rsp_count_one;
         r.st = rsp_status;
         heap_sb.check_item(r);
      end
   end

   // One item: random gap, raise start, wait for the accepting edge.
   // Start is held high across back-to-back items with no gap.
   task automatic send_item(logic [1:0] act, logic [9:0] v, logic sd, logic [31:0] g,
                            int gap);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start      <= 1'b1;
      req_action <= act;
      req_vertex <= v;
      req_side   <= sd;
      req_gain   <= g;
      do @(posedge clock); while (busy);
      heap_sb.note_item(act, v, sd, g);
      case (act)
         ACT_INSERT: n_ins++;
         ACT_REMOVE: n_rem++;
         default:    n_clr++;
      endcase
   endtask

   function automatic int draw_gap();
      // at least a third of items go back to back
      return ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 11);
   endfunction

   // random Q24.8 gain, often from a tiny set so ties are common
   function automatic logic [31:0] draw_gain();
      case ($urandom_range(0, 3))
         0:       return $urandom_range(0, 3) << 8;
         1:       return {$urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF};
         default: return $urandom();
      endcase
   endfunction

   task automatic drain();
      @(posedge clock);
      start <= 1'b0;
      while (heap_sb.pending.size() != 0) @(posedge clock);
   endtask

   initial begin
      logic [1:0] act;
      logic [9:0] v;
      int pool;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed: extremes, ties, both sides, bad insert/remove, clear
      send_item(ACT_INSERT, 10'd0,    1'b0, 32'h8000_0000, 0);
      send_item(ACT_INSERT, 10'd1023, 1'b0, 32'h7FFF_FFFF, 0);
      send_item(ACT_INSERT, 10'd5,    1'b0, 32'h0000_0100, 0);
      send_item(ACT_INSERT, 10'd6,    1'b0, 32'h0000_0100, 0);
      send_item(ACT_INSERT, 10'd7,    1'b0, 32'h0000_0100, 1);
      send_item(ACT_INSERT, 10'd5,    1'b1, 32'h0000_0200, 0);
      send_item(ACT_INSERT, 10'd512,  1'b1, 32'hFFFF_FF00, 0);
      send_item(ACT_INSERT, 10'd341,  1'b1, 32'h5555_5555, 0);
      send_item(ACT_INSERT, 10'd682,  1'b1, 32'hAAAA_AAAA, 2);
      send_item(ACT_REMOVE, 10'd1023, 1'b0, 32'h0, 0);
      send_item(ACT_REMOVE, 10'd341,  1'b0, 32'h0, 0);
      send_item(ACT_REMOVE, 10'd100,  1'b1, 32'h0, 0);
      send_item(ACT_REMOVE, 10'd0,    1'b0, 32'h0, 0);
      send_item(ACT_INSERT, 10'd0,    1'b0, 32'h0, 0);
      send_item(ACT_REMOVE, 10'd6,    1'b0, 32'h0, 3);
      send_item(ACT_NOP,    10'd9,    1'b1, 32'h0, 0);
      send_item(ACT_CLEAR,  10'd0,    1'b0, 32'h0, 0);
      send_item(ACT_REMOVE, 10'd5,    1'b0, 32'h0, 0);
      send_item(ACT_INSERT, 10'd5,    1'b1, 32'hFFFF_FFFF, 0);
      // hold off until everything has come back
      drain();

      // random: mostly inserts/removes; the vertex pool alternates between small and full
      for (int i = 0; i < 1430; i++) begin
         pool = (i % 400 < 200) ? 63 : 1023;
         case ($urandom_range(0, 99)) inside
            [0:54]:  act = ACT_INSERT;
            [55:96]: act = ACT_REMOVE;
            [97:98]: act = ACT_CLEAR;
            default: act = ACT_NOP;
         endcase
         v = 10'($urandom_range(0, pool));
         if ($urandom_range(0, 15) == 0) v = 10'($urandom());
         send_item(act, v, 1'($urandom_range(0, 1)), draw_gain(), draw_gap());
      end

      drain();
      repeat (200) @(posedge clock);
      $display("Covered %0d inserts, %0d removes, %0d clears/other; %0d results checked.",
               n_ins, n_rem, n_clr, heap_sb.checked);
      if (heap_sb.errors == 0 && heap_sb.pending.size() == 0)
         $display("dual_indexed_max_heap_core verification clean");
      else
         $display("dual_indexed_max_heap_core verification failed");
      $finish;
   end
endmodule

>>> dual_indexed_max_heap_core.f
sv/dimh_pkg.sv
sv/dimh_ram.sv
sv/dual_indexed_max_heap_core.sv
tb/tb.sv
